[src/morse_tone_generator_assert.svh]
// Assertion macros for the Morse tone generator.
// Included inside the modules that check their own logic; needs no package.
`ifndef MORSE_TONE_GENERATOR_ASSERT_SVH
`define MORSE_TONE_GENERATOR_ASSERT_SVH

// same-cycle implication
`define MTG_ASSERT_IMPL(name, ck, rn, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("mtg assertion failed");

// next-cycle implication
`define MTG_ASSERT_NEXT(name, ck, rn, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("mtg assertion failed");

`endif

[src/mtg_pkg.sv]
// Shared types, constants and the sine ROM contents for the Morse tone generator.
// No dependencies.
package mtg_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int SINE_DEPTH  = 1024;
    localparam int IDX_W       = $clog2(SINE_DEPTH);
    localparam int PHASE_W     = 32;
    localparam int LEN_W       = 20;
    localparam int OUT_W       = 16;
    localparam int SINE_FRAC_W = 15;
    localparam int MAG_W       = SINE_FRAC_W;
    localparam int PROD_W      = LEN_W + MAG_W;
    localparam int DEN_W       = LEN_W + SINE_FRAC_W;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [PHASE_W-1:0] PHASE_STEP_RST  = 32'd77913239;
    localparam logic [LEN_W-1:0]   DOT_RST         = 20'd2646;
    localparam logic [LEN_W-1:0]   DASH_RST        = 20'd7938;
    localparam logic [LEN_W-1:0]   LETTER_GAP_RST  = 20'd7938;
    localparam logic [LEN_W-1:0]   WORD_GAP_RST    = 20'd18522;

    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;

    localparam logic OP_SYMBOL = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    localparam logic [63:0] Q_TWO_PI  = 64'd6746518852;
    localparam logic [63:0] Q_PI      = 64'd3373259426;
    localparam logic [63:0] Q_HALF_PI = 64'd1686629713;

    typedef enum logic [2:0] {
        CFG_PHASE_STEP,
        CFG_DOT,
        CFG_DASH,
        CFG_LETTER_GAP,
        CFG_WORD_GAP
    } cfg_index_t;

    typedef enum logic [1:0] {
        ERR_NONE,
        ERR_UNKNOWN,
        ERR_BUSY
    } err_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_MULT,
        S_DSTART,
        S_DIV,
        S_FIN
    } state_t;

    typedef logic signed [OUT_W-1:0] sine_rom_t [SINE_DEPTH];

    function automatic logic [LEN_W-1:0] at_least_one(input logic [LEN_W-1:0] v);
        return (v == '0) ? LEN_W'(1) : v;
    endfunction

    // Q30 quarter-wave folded Taylor series, rounded to Q15
    function automatic logic signed [OUT_W-1:0] table_entry(input int unsigned k);
        logic [63:0] a;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] tt;
        logic [63:0] sum;
        logic [63:0] q;
        logic        neg;
        logic signed [OUT_W-1:0] r;
        a = (64'(k) * Q_TWO_PI) / SINE_DEPTH;
        neg = 1'b0;
        if (a > Q_PI)
        begin
            neg = 1'b1;
            a = a - Q_PI;
        end
        if (a > Q_HALF_PI)
            a = (Q_PI > a) ? Q_PI - a : 64'd0;
        x2 = (a * a) >> 30;
        t = a;
        sum = a;
        for (int i = 1; i <= 8; i++)
        begin
            tt = (t * x2) >> 30;
            case (i)
                1: t = tt / 6;
                2: t = tt / 20;
                3: t = tt / 42;
                4: t = tt / 72;
                5: t = tt / 110;
                6: t = tt / 156;
                7: t = tt / 210;
                default: t = tt / 272;
            endcase
            if ((i % 2) == 1)
                sum = (sum > t) ? sum - t : 64'd0;
            else
                sum = sum + t;
        end
        q = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
        if (q > 64'd32767)
            q = 64'd32767;
        r = OUT_W'(q);
        return neg ? -r : r;
    endfunction

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        for (int k = 0; k < SINE_DEPTH; k++)
        begin
            rom[k] = table_entry(k);
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

[src/morse_tone_generator.sv]
// Morse tone generator top level: sequencer, keyer state, sine ROM, output register.
// Depends on mtg_pkg, mtg_divider and morse_tone_generator_assert.svh.
// One word in, one word out. A symbol word, or a tick outside a tone, passes from the idle
// state to the final state, which loads its result into the output register. A tick
// inside a tone passes through a registered sine ROM read, one 20x15 multiply, a divider
// start state, then the wait state around the 16 steps of the serial divider that forms
// n*sine/N, then the final state. Output stalls hold the block in the final state. One word
// is in flight at a time; a finished word waits in the output register while the next is
// accepted. Config writes are taken at any time but are meant for idle.
module morse_tone_generator
    import mtg_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    op,
    input  logic [7:0]              symbol_char,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [OUT_W-1:0] sample,
    output logic                    sample_valid,
    output logic                    element_last,
    output logic                    busy_res,
    output logic [1:0]              error
);

    state_t state_reg, state_next;

    logic [PHASE_W-1:0] phase_step_reg;
    logic [LEN_W-1:0]   dot_reg, dash_reg, letter_gap_reg, word_gap_reg;

    logic [LEN_W-1:0]   sample_index_reg, sample_index_next;
    logic [LEN_W-1:0]   element_length_reg, element_length_next;
    logic               tone_active_reg, tone_active_next;
    logic [LEN_W-1:0]   pending_reg, pending_next;
    logic               prev_tone_reg, prev_tone_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic               playing_reg, playing_next;

    logic [LEN_W-1:0]        w_idx_reg, w_idx_next;
    logic [LEN_W-1:0]        w_len_reg, w_len_next;
    logic [IDX_W-1:0]        w_phase_reg, w_phase_next;
    logic signed [OUT_W-1:0] sine_reg, sine_next;
    logic [PROD_W-1:0]       prod_reg, prod_next;

    logic signed [OUT_W-1:0] res_sample_reg, res_sample_next;
    logic                    res_valid_reg, res_valid_next;
    logic                    res_last_reg, res_last_next;
    logic                    res_busy_reg, res_busy_next;
    err_t                    res_err_reg, res_err_next;

    logic                    out_valid_reg, out_valid_next;
    logic signed [OUT_W-1:0] out_sample_reg, out_sample_next;
    logic                    out_svalid_reg, out_svalid_next;
    logic                    out_last_reg, out_last_next;
    logic                    out_busy_reg, out_busy_next;
    err_t                    out_err_reg, out_err_next;

    logic                    div_start;
    logic                    div_done;
    logic [SAMPLE_BITS-1:0]  div_quotient;
    logic [DEN_W-1:0]        den;
    logic signed [OUT_W-1:0] sine_neg;
    logic [MAG_W-1:0]        sine_mag;

    assign sine_neg = -sine_reg;
    assign sine_mag = sine_reg[OUT_W-1] ? sine_neg[MAG_W-1:0] : sine_reg[MAG_W-1:0];
    // N * 32767
    assign den = DEN_W'({w_len_reg, {SINE_FRAC_W{1'b0}}}) - DEN_W'(w_len_reg);

    mtg_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .prod     (prod_reg),
        .den      (den),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb
    begin
        logic [LEN_W-1:0]  sel_len;
        logic [LEN_W-1:0]  si_inc;
        logic [OUT_W-1:0]  qc;
        state_next          = state_reg;
        in_ready            = 1'b0;
        div_start           = 1'b0;
        sel_len             = dot_reg;
        si_inc              = sample_index_reg + 1'b1;
        qc                  = '0;
        sample_index_next   = sample_index_reg;
        element_length_next = element_length_reg;
        tone_active_next    = tone_active_reg;
        pending_next        = pending_reg;
        prev_tone_next      = prev_tone_reg;
        phase_next          = phase_reg;
        playing_next        = playing_reg;
        w_idx_next          = w_idx_reg;
        w_len_next          = w_len_reg;
        w_phase_next        = w_phase_reg;
        sine_next           = sine_reg;
        prod_next           = prod_reg;
        res_sample_next     = res_sample_reg;
        res_valid_next      = res_valid_reg;
        res_last_next       = res_last_reg;
        res_busy_next       = res_busy_reg;
        res_err_next        = res_err_reg;
        out_valid_next      = out_valid_reg;
        out_sample_next     = out_sample_reg;
        out_svalid_next     = out_svalid_reg;
        out_last_next       = out_last_reg;
        out_busy_next       = out_busy_reg;
        out_err_next        = out_err_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    res_sample_next = '0;
                    res_valid_next  = 1'b0;
                    res_last_next   = 1'b0;
                    res_err_next    = ERR_NONE;
                    state_next      = S_FIN;
                    if (op == OP_SYMBOL)
                    begin
                        if (playing_reg)
                            res_err_next = ERR_BUSY;
                        else if (symbol_char == CHAR_DOT || symbol_char == CHAR_DASH)
                        begin
                            sel_len = (symbol_char == CHAR_DOT) ? dot_reg : dash_reg;
                            if (prev_tone_reg)
                            begin
                                pending_next        = at_least_one(sel_len);
                                element_length_next = at_least_one(dot_reg);
                                tone_active_next    = 1'b0;
                            end
                            else
                            begin
                                element_length_next = at_least_one(sel_len);
                                tone_active_next    = 1'b1;
                            end
                            sample_index_next = '0;
                            phase_next        = '0;
                            playing_next      = 1'b1;
                            prev_tone_next    = 1'b1;
                        end
                        else if (symbol_char == CHAR_SPACE || symbol_char == CHAR_SLASH)
                        begin
                            sel_len = (symbol_char == CHAR_SPACE) ? letter_gap_reg
                                                                  : word_gap_reg;
                            element_length_next = at_least_one(sel_len);
                            tone_active_next    = 1'b0;
                            sample_index_next   = '0;
                            phase_next          = '0;
                            playing_next        = 1'b1;
                            prev_tone_next      = 1'b0;
                        end
                        else
                            res_err_next = ERR_UNKNOWN;
                    end
                    else if (playing_reg)
                    begin
                        res_valid_next = 1'b1;
                        w_idx_next     = sample_index_reg;
                        w_len_next     = element_length_reg;
                        w_phase_next   = phase_reg[PHASE_W-1 -: IDX_W];
                        if (tone_active_reg)
                            state_next = S_LOOKUP;
                        phase_next = phase_reg + phase_step_reg;
                        if (si_inc >= element_length_reg)
                        begin
                            if (pending_reg != '0)
                            begin
                                element_length_next = pending_reg;
                                tone_active_next    = 1'b1;
                                sample_index_next   = '0;
                                phase_next          = '0;
                                pending_next        = '0;
                            end
                            else
                            begin
                                playing_next      = 1'b0;
                                tone_active_next  = 1'b0;
                                sample_index_next = '0;
                                res_last_next     = 1'b1;
                            end
                        end
                        else
                            sample_index_next = si_inc;
                    end
                    res_busy_next = playing_next;
                end
            end
            S_LOOKUP:
            begin
                sine_next  = SINE_ROM[w_phase_reg];
                state_next = S_MULT;
            end
            S_MULT:
            begin
                prod_next  = PROD_W'(w_idx_reg * sine_mag);
                state_next = S_DSTART;
            end
            S_DSTART:
            begin
                div_start  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    if (sine_reg[OUT_W-1])
                    begin
                        qc = (32'(div_quotient) > 32'd32768) ? OUT_W'(32768)
                                                             : OUT_W'(div_quotient);
                        res_sample_next = -$signed(qc);
                    end
                    else
                    begin
                        qc = (32'(div_quotient) > 32'd32767) ? OUT_W'(32767)
                                                             : OUT_W'(div_quotient);
                        res_sample_next = $signed(qc);
                    end
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_sample_next = res_sample_reg;
                    out_svalid_next = res_valid_reg;
                    out_last_next   = res_last_reg;
                    out_busy_next   = res_busy_reg;
                    out_err_next    = res_err_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            sample_index_reg   <= '0;
            element_length_reg <= '0;
            tone_active_reg    <= 1'b0;
            pending_reg        <= '0;
            prev_tone_reg      <= 1'b0;
            phase_reg          <= '0;
            playing_reg        <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            sample_index_reg   <= sample_index_next;
            element_length_reg <= element_length_next;
            tone_active_reg    <= tone_active_next;
            pending_reg        <= pending_next;
            prev_tone_reg      <= prev_tone_next;
            phase_reg          <= phase_next;
            playing_reg        <= playing_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg <= PHASE_STEP_RST;
            dot_reg        <= DOT_RST;
            dash_reg       <= DASH_RST;
            letter_gap_reg <= LETTER_GAP_RST;
            word_gap_reg   <= WORD_GAP_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_PHASE_STEP: phase_step_reg <= cfg_data[PHASE_W-1:0];
                CFG_DOT:        dot_reg        <= cfg_data[LEN_W-1:0];
                CFG_DASH:       dash_reg       <= cfg_data[LEN_W-1:0];
                CFG_LETTER_GAP: letter_gap_reg <= cfg_data[LEN_W-1:0];
                CFG_WORD_GAP:   word_gap_reg   <= cfg_data[LEN_W-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        w_idx_reg      <= w_idx_next;
        w_len_reg      <= w_len_next;
        w_phase_reg    <= w_phase_next;
        sine_reg       <= sine_next;
        prod_reg       <= prod_next;
        res_sample_reg <= res_sample_next;
        res_valid_reg  <= res_valid_next;
        res_last_reg   <= res_last_next;
        res_busy_reg   <= res_busy_next;
        res_err_reg    <= res_err_next;
        out_sample_reg <= out_sample_next;
        out_svalid_reg <= out_svalid_next;
        out_last_reg   <= out_last_next;
        out_busy_reg   <= out_busy_next;
        out_err_reg    <= out_err_next;
    end

    assign out_valid    = out_valid_reg;
    assign sample       = out_sample_reg;
    assign sample_valid = out_svalid_reg;
    assign element_last = out_last_reg;
    assign busy_res     = out_busy_reg;
    assign error        = out_err_reg;

`include "morse_tone_generator_assert.svh"

    // a pending tone only waits behind its gap
    `MTG_ASSERT_IMPL(a_pending_in_gap, clk, rst_n, pending_reg != '0,
        playing_reg && !tone_active_reg)
    `MTG_ASSERT_IMPL(a_index_in_element, clk, rst_n, playing_reg,
        sample_index_reg < element_length_reg)
    // ramp keeps the quotient inside the signed range
    `MTG_ASSERT_IMPL(a_quotient_range, clk, rst_n, state_reg == S_DIV && div_done,
        32'(div_quotient) < 32'd32768)
    `MTG_ASSERT_NEXT(a_tone_tick_lookup, clk, rst_n,
        state_reg == S_IDLE && in_valid && op == OP_TICK && playing_reg && tone_active_reg,
        state_reg == S_LOOKUP)

endmodule

[src/mtg_divider.sv]
// Restoring bit-serial divider: one quotient bit per cycle.
// Depends on mtg_pkg.
module mtg_divider
    import mtg_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [PROD_W-1:0]       prod,
    input  logic [DEN_W-1:0]        den,
    output logic                    done,
    output logic [SAMPLE_BITS-1:0]  quotient
);

    localparam int CNT_W = $clog2(SAMPLE_BITS + 1);

    logic                   run_reg, run_next;
    logic                   done_reg, done_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [DEN_W:0]         rem_reg, rem_next;
    logic [SAMPLE_BITS-1:0] lo_reg, lo_next;
    logic [SAMPLE_BITS-1:0] quo_reg, quo_next;

    logic [DEN_W:0] rem_sh;
    logic           ge;

    // numerator is prod << (SAMPLE_BITS-1); its upper part starts as remainder
    assign rem_sh = {rem_reg[DEN_W-1:0], lo_reg[SAMPLE_BITS-1]};
    assign ge     = rem_sh >= {1'b0, den};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        lo_next   = lo_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = CNT_W'(SAMPLE_BITS);
            rem_next = (DEN_W + 1)'(prod >> 1);
            lo_next  = {prod[0], {(SAMPLE_BITS - 1){1'b0}}};
            quo_next = '0;
        end
        else if (run_reg)
        begin
            rem_next = ge ? rem_sh - {1'b0, den} : rem_sh;
            lo_next  = lo_reg << 1;
            quo_next = {quo_reg[SAMPLE_BITS-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        lo_reg  <= lo_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
